// File: rtl/core/etfi_pkg.sv
// ----------------------------------------------------------------------------
// etfi_pkg
// Shared types, constants and the variant decoder of the escape-time
// fractal iterator.
// ----------------------------------------------------------------------------
package etfi_pkg;

    // Default fraction width of the internal fixed point and width of the count.
    localparam int FRAC_BITS_DEF   = 28;
    localparam int COUNT_WIDTH_DEF = 16;

    // Input points arrive as Q4.28.
    localparam int IN_WIDTH = 32;
    localparam int IN_FRAC  = 28;

    // Integer bits (sign included) of z and of the scaled products.
    localparam int Z_INT_BITS = 6;
    localparam int P_INT_BITS = 2 * Z_INT_BITS;

    // Result and configuration field widths.
    localparam int ITER_WIDTH    = 16;
    localparam int VARIANT_WIDTH = 4;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 1;

    localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = ITER_WIDTH'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FRACTAL_VARIANT = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_ITERATIONS  = 1'b1;

    // Partial products of one multiplication, in issue order.
    localparam int MUL_PARTIALS = 4;
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_LO_HI = 2'd1;
    localparam logic [1:0] PH_HI_LO = 2'd2;
    localparam logic [1:0] PH_HI_HI = 2'd3;

    // Iteration formulas.
    localparam logic [VARIANT_WIDTH-1:0] VAR_MANDELBROT    = 4'd0;
    localparam logic [VARIANT_WIDTH-1:0] VAR_TRICORN       = 4'd1;
    localparam logic [VARIANT_WIDTH-1:0] VAR_BURNING_SHIP  = 4'd2;
    localparam logic [VARIANT_WIDTH-1:0] VAR_PERP_MANDEL   = 4'd3;
    localparam logic [VARIANT_WIDTH-1:0] VAR_PERP_SHIP     = 4'd4;
    localparam logic [VARIANT_WIDTH-1:0] VAR_CELTIC        = 4'd5;
    localparam logic [VARIANT_WIDTH-1:0] VAR_CELTIC_CONJ   = 4'd6;
    localparam logic [VARIANT_WIDTH-1:0] VAR_BUFFALO       = 4'd7;
    localparam logic [VARIANT_WIDTH-1:0] VAR_PERP_CELTIC   = 4'd8;
    localparam logic [VARIANT_WIDTH-1:0] VAR_PERP_BUFFALO  = 4'd9;

    typedef struct packed {
        logic pre_abs_x;
        logic pre_abs_y;
        logic pre_neg_y;
        logic post_abs_a;
        logic post_abs_b;
        logic post_neg_b;
    } var_flags_t;

    // Controller to datapath.
    typedef struct packed {
        logic       load;
        logic       pre;
        logic [1:0] mul_phase;
        logic       pp_en;
        logic       acc_clr;
        logic       acc_en;
        logic       sums;
        logic       update;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic escape;
    } status_t;

    function automatic var_flags_t decode_variant(input logic [VARIANT_WIDTH-1:0] v);
        var_flags_t f;
        f = '0;
        case (v)
            VAR_TRICORN:      f.post_neg_b = 1'b1;
            VAR_BURNING_SHIP:
            begin
                f.pre_abs_x = 1'b1;
                f.pre_abs_y = 1'b1;
            end
            VAR_PERP_MANDEL:  f.pre_abs_y = 1'b1;
            VAR_PERP_SHIP:
            begin
                f.pre_abs_x = 1'b1;
                f.pre_neg_y = 1'b1;
            end
            VAR_CELTIC:       f.post_abs_a = 1'b1;
            VAR_CELTIC_CONJ:
            begin
                f.post_abs_a = 1'b1;
                f.post_neg_b = 1'b1;
            end
            VAR_BUFFALO:
            begin
                f.post_abs_a = 1'b1;
                f.post_abs_b = 1'b1;
            end
            VAR_PERP_CELTIC:
            begin
                f.pre_abs_y  = 1'b1;
                f.post_abs_a = 1'b1;
            end
            VAR_PERP_BUFFALO:
            begin
                f.pre_abs_x  = 1'b1;
                f.post_abs_a = 1'b1;
                f.post_neg_b = 1'b1;
            end
            default:          f = '0;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/core/etfi_mul.sv
// ----------------------------------------------------------------------------
// etfi_mul
// Signed fixed-point multiplier built from four half-width partial products,
// one per enabled cycle, with the result floored to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module etfi_mul
    import etfi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic signed [FRAC_BITS+Z_INT_BITS-1:0] a,
    input  logic signed [FRAC_BITS+Z_INT_BITS-1:0] b,
    input  logic [1:0]                            phase,
    input  logic                                  pp_en,
    input  logic                                  acc_clr,
    input  logic                                  acc_en,
    output logic signed [FRAC_BITS+P_INT_BITS-1:0] prod
);

    localparam int W    = FRAC_BITS + Z_INT_BITS;
    localparam int L    = W / 2;
    localparam int H    = W - L;
    localparam int OPW  = H + 1;
    localparam int PPW  = 2 * OPW;
    localparam int ACCW = 2 * W;

    logic signed [OPW-1:0]  a_lo, a_hi, b_lo, b_hi;
    logic signed [OPW-1:0]  op_a, op_b;
    logic signed [PPW-1:0]  pp_reg;
    logic [1:0]             shift_reg;
    logic signed [ACCW-1:0] pp_ext, term;
    logic signed [ACCW-1:0] acc_reg;

    // The low halves are unsigned, the high halves carry the sign.
    assign a_lo = $signed({{(OPW-L){1'b0}}, a[L-1:0]});
    assign b_lo = $signed({{(OPW-L){1'b0}}, b[L-1:0]});
    assign a_hi = $signed({{(OPW-H){a[W-1]}}, a[W-1:L]});
    assign b_hi = $signed({{(OPW-H){b[W-1]}}, b[W-1:L]});

    always_comb
    begin
        case (phase)
            PH_LO_LO:
            begin
                op_a = a_lo;
                op_b = b_lo;
            end
            PH_LO_HI:
            begin
                op_a = a_lo;
                op_b = b_hi;
            end
            PH_HI_LO:
            begin
                op_a = a_hi;
                op_b = b_lo;
            end
            default:
            begin
                op_a = a_hi;
                op_b = b_hi;
            end
        endcase
    end

    assign pp_ext = ACCW'(pp_reg);

    always_comb
    begin
        case (shift_reg)
            PH_LO_LO: term = pp_ext;
            PH_LO_HI: term = pp_ext <<< L;
            PH_HI_LO: term = pp_ext <<< L;
            default:  term = pp_ext <<< (2 * L);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pp_en)
        begin
            pp_reg    <= op_a * op_b;
            shift_reg <= phase;
        end
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (acc_en)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    // Dropping the low fraction bits of the exact product floors it.
    assign prod = acc_reg[ACCW-1:FRAC_BITS];

endmodule

// File: rtl/core/etfi_datapath.sv
// ----------------------------------------------------------------------------
// etfi_datapath
// Holds c and z, forms x*x, y*y and x*y on three multipliers and applies
// the selected formula and the escape test.
// ----------------------------------------------------------------------------
module etfi_datapath
    import etfi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  cmd_t                        cmd,
    input  var_flags_t                  flags,
    input  logic signed [IN_WIDTH-1:0]  c_re,
    input  logic signed [IN_WIDTH-1:0]  c_im,
    output status_t                     status
);

    localparam int W  = FRAC_BITS + Z_INT_BITS;
    localparam int PW = FRAC_BITS + P_INT_BITS;
    localparam logic signed [PW-1:0] ESC_LIMIT = PW'(64'd4 << FRAC_BITS);

    logic signed [W-1:0]  cre_conv, cim_conv;
    logic signed [W-1:0]  cr_reg, ci_reg;
    logic signed [W-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [PW-1:0] a_reg, b_reg;
    logic                 esc_reg;
    logic signed [PW-1:0] sq_x, sq_y, xy;
    logic signed [PW-1:0] sq_sum;
    logic signed [PW-1:0] cr_ext, ci_ext, x_upd, y_upd;
    logic                 x_flip, y_flip, a_flip, b_flip;

    // Bring c to the internal fraction width, flooring when bits are lost.
    generate
        if (FRAC_BITS >= IN_FRAC)
        begin : g_widen
            assign cre_conv = W'(c_re) <<< (FRAC_BITS - IN_FRAC);
            assign cim_conv = W'(c_im) <<< (FRAC_BITS - IN_FRAC);
        end
        else
        begin : g_narrow
            assign cre_conv = W'(c_re >>> (IN_FRAC - FRAC_BITS));
            assign cim_conv = W'(c_im >>> (IN_FRAC - FRAC_BITS));
        end
    endgenerate

    etfi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx
    (
        .clk     (clk),
        .a       (x_reg),
        .b       (x_reg),
        .phase   (cmd.mul_phase),
        .pp_en   (cmd.pp_en),
        .acc_clr (cmd.acc_clr),
        .acc_en  (cmd.acc_en),
        .prod    (sq_x)
    );

    etfi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_yy
    (
        .clk     (clk),
        .a       (y_reg),
        .b       (y_reg),
        .phase   (cmd.mul_phase),
        .pp_en   (cmd.pp_en),
        .acc_clr (cmd.acc_clr),
        .acc_en  (cmd.acc_en),
        .prod    (sq_y)
    );

    etfi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xy
    (
        .clk     (clk),
        .a       (x_reg),
        .b       (y_reg),
        .phase   (cmd.mul_phase),
        .pp_en   (cmd.pp_en),
        .acc_clr (cmd.acc_clr),
        .acc_en  (cmd.acc_en),
        .prod    (xy)
    );

    // Sign changes of the pre-transform on x and y.
    assign x_flip = flags.pre_abs_x & x_reg[W-1];
    assign y_flip = (flags.pre_abs_y & y_reg[W-1]) ^ flags.pre_neg_y;

    // The post-transform folds into the add of c as an add or a subtract.
    assign a_flip = flags.post_abs_a & a_reg[PW-1];
    assign b_flip = (flags.post_abs_b & b_reg[PW-1]) ^ flags.post_neg_b;
    assign cr_ext = PW'(cr_reg);
    assign ci_ext = PW'(ci_reg);
    assign x_upd  = a_flip ? (cr_ext - a_reg) : (cr_ext + a_reg);
    assign y_upd  = b_flip ? (ci_ext - b_reg) : (ci_ext + b_reg);

    assign sq_sum = sq_x + sq_y;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.load)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (cmd.pre)
        begin
            x_next = x_flip ? -x_reg : x_reg;
            y_next = y_flip ? -y_reg : y_reg;
        end
        else if (cmd.update)
        begin
            x_next = W'(x_upd);
            y_next = W'(y_upd);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        if (cmd.load)
        begin
            cr_reg <= cre_conv;
            ci_reg <= cim_conv;
        end
        if (cmd.sums)
        begin
            a_reg   <= sq_x - sq_y;
            b_reg   <= xy <<< 1;
            esc_reg <= sq_sum > ESC_LIMIT;
        end
    end

    assign status.escape = esc_reg;

endmodule

// File: rtl/core/etfi_ctrl.sv
// ----------------------------------------------------------------------------
// etfi_ctrl
// Sequencer of the iterator: steps each iteration through its phases,
// counts iterations and registers the result.
// ----------------------------------------------------------------------------
module etfi_ctrl
    import etfi_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ITER_WIDTH-1:0] max_iterations,
    input  status_t               status,
    output cmd_t                  cmd,
    output logic                  busy,
    output logic                  done,
    output logic [ITER_WIDTH-1:0] iteration_count,
    output logic                  escaped
);

    localparam int OUT_W = (COUNT_WIDTH < ITER_WIDTH) ? COUNT_WIDTH : ITER_WIDTH;
    localparam int PH_W  = $clog2(MUL_PARTIALS + 1);
    localparam logic [PH_W-1:0] PH_DRAIN = PH_W'(MUL_PARTIALS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRE    = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_SUMS   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [PH_W-1:0]       phase_reg, phase_next;
    logic [ITER_WIDTH-1:0] iter_reg, iter_next;
    logic                  done_reg, done_next;
    logic                  escaped_reg, escaped_next;
    logic [OUT_W-1:0]      count_reg, count_next;
    logic [ITER_WIDTH-1:0] iter_less;

    assign iter_less = iter_reg - ITER_WIDTH'(1);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        iter_next    = iter_reg;
        done_next    = 1'b0;
        escaped_next = escaped_reg;
        count_next   = count_reg;
        cmd          = '0;
        cmd.mul_phase = phase_reg[1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                phase_next = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // Four partial products are issued; the last phase only drains.
                cmd.pp_en   = (phase_reg != PH_DRAIN);
                cmd.acc_clr = (phase_reg == '0);
                cmd.acc_en  = (phase_reg != '0);
                if (phase_reg == PH_DRAIN)
                begin
                    state_next = S_SUMS;
                end
                else
                begin
                    phase_next = phase_reg + PH_W'(1);
                end
            end
            S_SUMS:
            begin
                cmd.sums   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.escape)
                begin
                    done_next    = 1'b1;
                    escaped_next = 1'b1;
                    count_next   = iter_less[OUT_W-1:0];
                    state_next   = S_IDLE;
                end
                else if (iter_reg == max_iterations)
                begin
                    done_next    = 1'b1;
                    escaped_next = 1'b0;
                    count_next   = max_iterations[OUT_W-1:0];
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.update = 1'b1;
                    iter_next  = iter_reg + ITER_WIDTH'(1);
                    state_next = S_PRE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= '0;
            iter_reg    <= '0;
            done_reg    <= 1'b0;
            escaped_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            iter_reg    <= iter_next;
            done_reg    <= done_next;
            escaped_reg <= escaped_next;
            count_reg   <= count_next;
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign escaped         = escaped_reg;
    assign iteration_count = ITER_WIDTH'(count_reg);

endmodule

// File: rtl/core/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Escape-time iterator for the Mandelbrot family of fractals, Burning Ship
// and related variants included, in signed fixed point.
// ----------------------------------------------------------------------------
// A point c (c_re, c_im, signed Q4.28) is taken as a request at a rising edge
// where start is high and busy is low. Starting from z = 0 the block repeats
// z = F(z) + c and reports the first zero-based iteration index at which
// |z|^2 exceeds 4, with escaped high; a point that stays bounded for
// max_iterations steps reports max_iterations with escaped low. The result
// is presented on iteration_count and escaped, marked by done for exactly
// one cycle; the receiver cannot stall it, so it must capture the result in
// that cycle. Each iteration applies the input sign transform of the selected
// formula to z, then runs the three shared-time multipliers (x*x, y*y and
// x*y, each built from four half-width partial products issued one per
// cycle, followed by a drain step), then forms the sums and the escape test,
// and finally decides and writes back the new z.
// busy falls in the cycle in which done is shown, so the next request can
// be accepted in that very cycle.
//
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle: a rule for the user; the block itself does not enforce it.
// Register 0 is fractal_variant (formulas 0 to 9; codes 10 to 15 behave as
// the plain Mandelbrot set), register 1 is max_iterations (reset value 256).
// With a limit of zero the block answers 0, not escaped.
//
// Internally z carries FRAC_BITS fraction bits and six integer bits, and
// each product is floored back to FRAC_BITS fraction bits. Because the loop
// stops as soon as |z| exceeds 2, no value can overflow. The reported count
// is truncated to COUNT_WIDTH bits.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator
    import etfi_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Configuration write port.
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data,

    // Request side.
    input  logic                     start,
    output logic                     busy,
    input  logic signed [IN_WIDTH-1:0] c_re,
    input  logic signed [IN_WIDTH-1:0] c_im,

    // Result side.
    output logic                     done,
    output logic [ITER_WIDTH-1:0]    iteration_count,
    output logic                     escaped
);

    logic [VARIANT_WIDTH-1:0] fractal_variant_reg;
    logic [ITER_WIDTH-1:0]    max_iterations_reg;
    var_flags_t               flags;
    cmd_t                     cmd;
    status_t                  status;

    // Configuration registers. Only the low bits of the data are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fractal_variant_reg <= VAR_MANDELBROT;
            max_iterations_reg  <= MAX_ITER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRACTAL_VARIANT: fractal_variant_reg <= cfg_data[VARIANT_WIDTH-1:0];
                REG_MAX_ITERATIONS:  max_iterations_reg  <= cfg_data[ITER_WIDTH-1:0];
                default:             max_iterations_reg  <= max_iterations_reg;
            endcase
        end
    end

    // The variant is decoded into the sign transforms applied before the
    // multiplications and after the squares are combined.
    assign flags = decode_variant(fractal_variant_reg);

    etfi_ctrl #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .max_iterations  (max_iterations_reg),
        .status          (status),
        .cmd             (cmd),
        .busy            (busy),
        .done            (done),
        .iteration_count (iteration_count),
        .escaped         (escaped)
    );

    etfi_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath
    (
        .clk    (clk),
        .cmd    (cmd),
        .flags  (flags),
        .c_re   (c_re),
        .c_im   (c_im),
        .status (status)
    );

endmodule
